// ===== design/sdp_pkg.sv =====
// Package for the SDP RFCOMM channel extractor: parse phases, sizes and constants.
// No dependencies.
package sdp_pkg;

  localparam int unsigned PosW = 17;
  localparam int unsigned LenW = 33;
  localparam logic [PosW-1:0] PosMax = 17'h1FFFF;
  localparam logic [15:0] UuidRfcomm = 16'h0003;
  localparam logic [15:0] AttrProtoList = 16'h0004;
  localparam logic [4:0] TypeUint = 5'd1;
  localparam logic [4:0] TypeUuid = 5'd3;
  localparam logic [4:0] TypeSeq = 5'd6;

  typedef enum logic [4:0] {
    PH_CNT_HI    = 5'd0,
    PH_CNT_LO    = 5'd1,
    PH_OSEQ_HEAD = 5'd2,
    PH_OSEQ_LEN  = 5'd3,
    PH_AID_HEAD  = 5'd4,
    PH_AID_LEN   = 5'd5,
    PH_AID_VAL   = 5'd6,
    PH_AVAL_HEAD = 5'd7,
    PH_AVAL_LEN  = 5'd8,
    PH_SKIP_ATTR = 5'd9,
    PH_PSEQ_HEAD = 5'd10,
    PH_PSEQ_LEN  = 5'd11,
    PH_UUID_HEAD = 5'd12,
    PH_UUID_LEN  = 5'd13,
    PH_UUID_VAL  = 5'd14,
    PH_CHAN_HEAD = 5'd15,
    PH_CHAN_LEN  = 5'd16,
    PH_CHAN_VAL  = 5'd17,
    PH_SKIP_DESC = 5'd18,
    PH_DONE      = 5'd19
  } phase_e;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] channel;
  } out_item_t;

  // Size of an element given inline by its descriptor (0..4).
  function automatic logic [LenW-1:0] inline_size(input logic [2:0] desc);
    logic [LenW-1:0] s;
    begin
      case (desc)
        3'd0: s = LenW'(1);
        3'd1: s = LenW'(2);
        3'd2: s = LenW'(4);
        3'd3: s = LenW'(8);
        3'd4: s = LenW'(16);
        default: s = '0;
      endcase
      return s;
    end
  endfunction

  // Number of length bytes following the header for descriptors 5..7.
  function automatic logic [4:0] extra_bytes(input logic [2:0] desc);
    logic [4:0] n;
    begin
      case (desc)
        3'd5: n = 5'd1;
        3'd6: n = 5'd2;
        default: n = 5'd4;
      endcase
      return n;
    end
  endfunction

endpackage

// ===== design/sdp_stream_if.sv =====
// Valid/ready stream interface with a generic payload type.
// Depends on sdp_pkg only through the payload types chosen by users.
interface sdp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sdp_parser.sv =====
// Parser state and its one-byte step: all parse state registers live here.
// Depends on sdp_pkg.
module sdp_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output logic                  res_valid_o,
  output sdp_pkg::out_item_t    res_o
);
  import sdp_pkg::*;

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [15:0]       count_q, count_d;
  logic [PosW-1:0]   oend_q, oend_d;
  logic [PosW-1:0]   aend_q, aend_d;
  logic [PosW-1:0]   dend_q, dend_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [15:0]       shift_q, shift_d;
  logic [4:0]        hleft_q, hleft_d;
  logic [7:0]        chan_q, chan_d;
  logic              latched_q, latched_d;
  logic              ofail_q, ofail_d;

  // Failure: inside the descriptor walk abandon the attribute, else stop.
  function automatic logic inner(input phase_e p);
    return (p >= PH_PSEQ_HEAD) && (p <= PH_SKIP_DESC);
  endfunction

  always_comb begin
    phase_e           ph;
    logic [PosW-1:0]  b;
    logic [PosW-1:0]  p;
    logic [PosW-1:0]  p1;
    logic [LenW-1:0]  size;
    logic [LenW:0]    endv;
    phase_e           kind;
    logic             hd;
    logic             fail;
    logic [4:0]       want;
    logic [4:0]       hl;
    logic [15:0]      fs;
    logic             ok;

    phase_d   = phase_q;
    pos_d     = pos_q;
    count_d   = count_q;
    oend_d    = oend_q;
    aend_d    = aend_q;
    dend_d    = dend_q;
    len_d     = len_q;
    shift_d   = shift_q;
    hleft_d   = hleft_q;
    chan_d    = chan_q;
    latched_d = latched_q;
    ofail_d   = ofail_q;
    res_valid_o = 1'b0;
    res_o     = '0;

    b    = pos_q;
    p    = b - PosW'(2);
    p1   = p + PosW'(1);
    hd   = 1'b0;
    fail = 1'b0;
    kind = PH_OSEQ_HEAD;
    size = '0;
    ph   = phase_q;
    want = '0;
    hl   = '0;
    fs   = '0;
    endv = '0;
    ok   = 1'b0;

    if (step_i) begin
      if (phase_q == PH_CNT_HI) begin
        count_d = {byte_i, 8'h00};
        phase_d = PH_CNT_LO;
      end else if (phase_q == PH_CNT_LO) begin
        count_d = {count_q[15:8], byte_i};
        phase_d = PH_OSEQ_HEAD;
        // Settle at position zero: only a zero count fails here.
        if (count_d == 16'd0) begin
          ofail_d = 1'b1;
          phase_d = PH_DONE;
        end
      end else if (phase_q != PH_DONE && b >= PosW'(2) && p < {1'b0, count_q}) begin
        // Consume one body byte.
        case (ph)
          PH_OSEQ_HEAD, PH_AID_HEAD, PH_AVAL_HEAD,
          PH_PSEQ_HEAD, PH_UUID_HEAD, PH_CHAN_HEAD: begin
            if (ph == PH_UUID_HEAD) want = TypeUuid;
            else if (ph == PH_AID_HEAD || ph == PH_CHAN_HEAD) want = TypeUint;
            else want = TypeSeq;
            if (byte_i[7:3] != want) begin
              fail = 1'b1;
            end else if (byte_i[2:0] < 3'd5) begin
              len_d = inline_size(byte_i[2:0]);
              hd    = 1'b1;
              kind  = ph;
            end else begin
              len_d   = '0;
              hleft_d = extra_bytes(byte_i[2:0]);
              phase_d = phase_e'(ph + 5'd1);
            end
          end
          PH_OSEQ_LEN, PH_AID_LEN, PH_AVAL_LEN,
          PH_PSEQ_LEN, PH_UUID_LEN, PH_CHAN_LEN: begin
            len_d = {len_q[LenW-9:0], byte_i};
            hl = (hleft_q != 5'd0) ? hleft_q - 5'd1 : 5'd0;
            hleft_d = hl;
            if (hl == 5'd0) begin
              hd   = 1'b1;
              kind = phase_e'(ph - 5'd1);
            end
          end
          PH_AID_VAL, PH_UUID_VAL: begin
            fs = {shift_q[7:0], byte_i};
            shift_d = fs;
            hl = (hleft_q != 5'd0) ? hleft_q - 5'd1 : 5'd0;
            hleft_d = hl;
            if (hl == 5'd0) begin
              if (ph == PH_AID_VAL) phase_d = PH_AVAL_HEAD;
              else if (len_q == LenW'(2) && fs == UuidRfcomm) phase_d = PH_CHAN_HEAD;
              else phase_d = PH_SKIP_DESC;
            end
          end
          PH_CHAN_VAL: begin
            if (byte_i != 8'd0) begin
              chan_d    = byte_i;
              latched_d = 1'b1;
              phase_d   = PH_DONE;
            end else begin
              phase_d = PH_SKIP_ATTR;
            end
          end
          default: ;
        endcase

        // Header complete: check the element's extent.
        if (hd) begin
          size = len_d;
          endv = {1'b0, LenW'(p1)} + {1'b0, size};
          case (kind)
            PH_OSEQ_HEAD: begin
              if (endv > (LenW+1)'(count_q)) fail = 1'b1;
              else begin
                oend_d  = endv[PosW-1:0];
                phase_d = PH_AID_HEAD;
              end
            end
            PH_AID_HEAD: begin
              if (size != LenW'(2)) fail = 1'b1;
              else begin
                hleft_d = 5'd2;
                shift_d = '0;
                phase_d = PH_AID_VAL;
              end
            end
            PH_AVAL_HEAD: begin
              if (endv > (LenW+1)'(count_q)) fail = 1'b1;
              else begin
                aend_d  = endv[PosW-1:0];
                phase_d = (shift_q == AttrProtoList) ? PH_PSEQ_HEAD : PH_SKIP_ATTR;
              end
            end
            PH_PSEQ_HEAD: begin
              if (endv > (LenW+1)'(aend_q)) fail = 1'b1;
              else begin
                dend_d  = endv[PosW-1:0];
                phase_d = PH_UUID_HEAD;
              end
            end
            PH_UUID_HEAD: begin
              if ((size != LenW'(2) && size != LenW'(4) && size != LenW'(16))
                  || endv > (LenW+1)'(dend_q)) fail = 1'b1;
              else begin
                hleft_d = size[4:0];
                shift_d = '0;
                phase_d = PH_UUID_VAL;
              end
            end
            default: begin
              if (size != LenW'(1)) fail = 1'b1;
              else phase_d = PH_CHAN_VAL;
            end
          endcase
        end

        if (fail) begin
          if (inner(ph)) phase_d = PH_SKIP_ATTR;
          else begin
            ofail_d = 1'b1;
            phase_d = PH_DONE;
          end
        end

        // Settle: follow end-of-region transitions at position p+1.
        for (int i = 0; i < 6; i++) begin
          case (phase_d)
            PH_AID_HEAD: begin
              if (p1 >= oend_d) phase_d = PH_DONE;
              else if (p1 >= {1'b0, count_q}) begin
                ofail_d = 1'b1;
                phase_d = PH_DONE;
              end
            end
            PH_SKIP_ATTR: if (p1 >= aend_d) phase_d = PH_AID_HEAD;
            PH_SKIP_DESC: if (p1 >= dend_d) phase_d = PH_PSEQ_HEAD;
            PH_PSEQ_HEAD: if (p1 >= aend_d) phase_d = PH_SKIP_ATTR;
            PH_UUID_HEAD, PH_UUID_LEN, PH_UUID_VAL:
              if (p1 >= dend_d) phase_d = PH_SKIP_ATTR;
            PH_PSEQ_LEN, PH_CHAN_HEAD, PH_CHAN_LEN, PH_CHAN_VAL:
              if (p1 >= aend_d) phase_d = PH_SKIP_ATTR;
            PH_OSEQ_HEAD, PH_OSEQ_LEN, PH_AID_LEN, PH_AID_VAL,
            PH_AVAL_HEAD, PH_AVAL_LEN: begin
              if (p1 >= {1'b0, count_q}) begin
                ofail_d = 1'b1;
                phase_d = PH_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      if (pos_q != PosMax) pos_d = pos_q + PosW'(1);

      // Last byte: report and return to reset.
      if (last_i) begin
        ok = latched_d && pos_d >= PosW'(3) && pos_d >= PosW'(2) + {1'b0, count_d};
        res_valid_o   = 1'b1;
        res_o.found   = ok;
        res_o.channel = ok ? chan_d : 8'd0;
        phase_d   = PH_CNT_HI;
        pos_d     = '0;
        count_d   = '0;
        oend_d    = '0;
        aend_d    = '0;
        dend_d    = '0;
        len_d     = '0;
        shift_d   = '0;
        hleft_d   = '0;
        chan_d    = '0;
        latched_d = 1'b0;
        ofail_d   = 1'b0;
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CNT_HI;
      pos_q     <= '0;
      count_q   <= '0;
      oend_q    <= '0;
      aend_q    <= '0;
      dend_q    <= '0;
      len_q     <= '0;
      shift_q   <= '0;
      hleft_q   <= '0;
      chan_q    <= '0;
      latched_q <= 1'b0;
      ofail_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      count_q   <= count_d;
      oend_q    <= oend_d;
      aend_q    <= aend_d;
      dend_q    <= dend_d;
      len_q     <= len_d;
      shift_q   <= shift_d;
      hleft_q   <= hleft_d;
      chan_q    <= chan_d;
      latched_q <= latched_d;
      ofail_q   <= ofail_d;
    end
  end

endmodule

// ===== design/sdp_rfcomm_channel_extractor.sv =====
// Top level of the SDP RFCOMM channel extractor: input register, parser, result register.
// Depends on sdp_pkg, sdp_stream_if and sdp_parser.
//
//   Channel   Direction  Payload
//   in_if     sink       body_byte[7:0], last
//   out_if    source     found, channel[7:0]
//
// One byte is taken every cycle while input is not stalled; a byte waits in the input
// register and its result, if any, is written to the result register when it advances.
// Reset clears the parse state and both valid flags.
// A stalled result holds; input is stalled only while the input register holds
// a last byte, the result register is full and the result is not taken.
module sdp_rfcomm_channel_extractor (
  input  logic clk_i,
  input  logic rst_ni,
  sdp_stream_if.sink   in_if,
  sdp_stream_if.source out_if
);
  import sdp_pkg::*;

  logic       in_vld_q;
  in_item_t   in_q;
  logic       out_vld_q;
  out_item_t  out_q;
  logic       res_valid;
  out_item_t  res;
  logic       step;
  logic       out_free;

  // A result slot is free if empty or being taken now.
  assign out_free = !out_vld_q || out_if.ready;
  // The registered byte advances when its result (if any) can be stored.
  assign step = in_vld_q && (out_free || !in_q.last);
  assign in_if.ready = !in_vld_q || step;

  sdp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_q.body_byte),
    .last_i      (in_q.last),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_q <= in_if.payload;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_if.valid   = out_vld_q;
  assign out_if.payload = out_q;

endmodule

// ===== design/sdp_checker.sv =====
// Port-level checker for the SDP RFCOMM channel extractor, bound to the top level.
// Depends on sdp_pkg.
module sdp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_last_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input sdp_pkg::out_item_t out_item_i
);
  import sdp_pkg::*;

  // A result never claims a channel of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.found |-> out_item_i.channel != 8'd0)
    else $error("found result with zero channel");

  // A not-found result carries channel zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.found |-> out_item_i.channel == 8'd0)
    else $error("not-found result with nonzero channel");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result changed");

  // With an empty result side, input is never refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && $past(!out_valid_i) && $past(!(in_valid_i && in_last_i)) |-> in_ready_i)
    else $error("input refused while result side empty");

endmodule

bind sdp_rfcomm_channel_extractor sdp_checker u_sdp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_last_i   (in_if.payload.last),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_item_i  (out_if.payload)
);
